### hdl/open_addressing_hash_table_macros.svh
// ----------------------------------------------------------------------------
// open addressing hash table assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH

// property that must hold at every edge outside reset
`define OAHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// shared constants, codes, command/status types for the hash table
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

    localparam int SLOTS      = 1024;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int KEY_W      = 31;
    localparam int CFG_W      = 11;
    localparam int IDX_W      = 2;
    localparam int REQ_W      = 2;
    localparam int ST_W       = 3;
    localparam int TOTAL_W    = 32;
    localparam int DVS_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int IN_DATA_W  = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = SLOT_W + CNT_W + TOTAL_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_CLEARED   = 3'd4;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SECOND_MOD = 2'd1;
    localparam logic [IDX_W-1:0] CFG_PROBE_MODE = 2'd2;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1024;
    localparam logic [CFG_W-1:0] SECOND_MOD_RST = 11'd1023;

    // remainder unit operand selection
    typedef logic [1:0] dsel_t;
    localparam dsel_t DSEL_HASH   = 2'd0;
    localparam dsel_t DSEL_SECOND = 2'd1;
    localparam dsel_t DSEL_STEP   = 2'd2;

    typedef struct packed {
        logic              accept;
        logic              div_start;
        dsel_t             div_sel;
        logic              scan_init;
        logic              scan_en;
        logic              wipe_en;
        logic              capture;
        logic              out_load;
        logic [REQ_W-1:0]  op;
    } oaht_cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic wipe_done;
        logic out_free;
        logic double_mode;
    } oaht_stat_t;

    // slots in use: zero counts as one, clipped to the table depth
    function automatic logic [CNT_W-1:0] used_size(input logic [CFG_W-1:0] ts);
        logic [CNT_W-1:0] r;
        if (ts == '0)
            r = CNT_W'(1);
        else if (int'(ts) > SLOTS)
            r = CNT_W'(SLOTS);
        else
            r = CNT_W'(ts);
        return r;
    endfunction

    // secondary modulus: zero counts as one
    function automatic logic [CFG_W-1:0] used_mod(input logic [CFG_W-1:0] sm);
        return (sm == '0) ? CFG_W'(1) : sm;
    endfunction

endpackage

`default_nettype wire

### hdl/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// open-addressing key table with linear or double-hash probing
// ----------------------------------------------------------------------------
// usage
//   s_* carries requests: s_tuser is the request kind (insert, lookup, clear),
//   s_tdata the key. m_* returns one result per insert, lookup or clear: m_tuser the status,
//   m_tdata slot, collisions of this insert and the running collision total.
//   cfg_* writes table size, secondary modulus and probe mode; write only
//   while no request is in flight. cfg_ready is always high.
// work per request (one request at a time, set by the single memory read port
// and the bit-serial remainder unit)
//   insert, linear:  one modulo, then probes, probes <= table size
//   insert, double:  three modulos, then probes
//   lookup:          slots scanned, up to table size
//   clear:           all SLOTS memory rows wiped (one memory row per cycle)
// reset
//   all slots are marked empty by a wipe pass over every slot; s_tready stays low
//   during the pass. config returns to its reset values, total to zero.
// stall
//   a result waits in the output register while m_tready is low; the next
//   request is taken meanwhile and holds its own result until the output frees
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_table
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // request channel
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [oaht_pkg::IN_DATA_W-1:0]     s_tdata,  // key, zero pad
    input  wire logic [oaht_pkg::REQ_W-1:0]         s_tuser,  // req_type
    // result channel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [oaht_pkg::OUT_DATA_W-1:0]         m_tdata,  // slot, probe_collisions,
                                                              // total_collisions, zero pad
    output logic [oaht_pkg::ST_W-1:0]               m_tuser,  // status
    // register write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [oaht_pkg::IDX_W-1:0]         cfg_index,
    input  wire logic [oaht_pkg::CFG_W-1:0]         cfg_data
);

    oaht_pkg::oaht_cmd_t   cmd;
    oaht_pkg::oaht_stat_t  stat;

    // registers are always writable, the block is idle by contract
    assign cfg_ready = 1'b1;

    // sequencer: one request from transfer to result
    oaht_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: slot memory, hashing, probe pipeline, output register
    oaht_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .key       (s_tdata[oaht_pkg::KEY_W-1:0]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

### hdl/oaht_rem.sv
// ----------------------------------------------------------------------------
// oaht_rem
// bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "open_addressing_hash_table_macros.svh"

module oaht_rem
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [oaht_pkg::KEY_W-1:0]   dividend,
    input  wire logic [oaht_pkg::DVS_W-1:0]   divisor,
    output logic                              done,
    output logic [oaht_pkg::DVS_W-1:0]        rem
);

    localparam int IT_W = $clog2(oaht_pkg::KEY_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [IT_W-1:0]              it_reg, it_next;
    logic [oaht_pkg::KEY_W-1:0]   dvd_reg;
    logic [oaht_pkg::DVS_W-1:0]   dvs_reg;
    logic [oaht_pkg::DVS_W-1:0]   rem_reg;
    logic [oaht_pkg::DVS_W:0]     part;
    logic [oaht_pkg::DVS_W+1:0]   sub;
    logic [oaht_pkg::DVS_W-1:0]   rem_step;

    // shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        part     = {rem_reg, dvd_reg[oaht_pkg::KEY_W-1]};
        sub      = {1'b0, part} - {2'b00, dvs_reg};
        rem_step = sub[oaht_pkg::DVS_W+1] ? part[oaht_pkg::DVS_W-1:0]
                                          : sub[oaht_pkg::DVS_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        it_next   = it_reg;
        if (start)
        begin
            busy_next = 1'b1;
            it_next   = '0;
        end
        else if (busy_reg)
        begin
            it_next = it_reg + IT_W'(1);
            if (it_reg == IT_W'(oaht_pkg::KEY_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[oaht_pkg::KEY_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `OAHT_ASSERT(a_no_restart, start |-> !busy_reg, "remainder unit restarted while busy")

endmodule

`default_nettype wire

### hdl/oaht_dp.sv
// ----------------------------------------------------------------------------
// oaht_dp
// datapath: registers, slot memory, probe pipeline, result and output stage
// ----------------------------------------------------------------------------
`default_nettype none
`include "open_addressing_hash_table_macros.svh"

module oaht_dp
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire oaht_pkg::oaht_cmd_t              cmd,
    output oaht_pkg::oaht_stat_t                  stat,
    input  wire logic [oaht_pkg::KEY_W-1:0]       key,
    input  wire logic                             cfg_valid,
    input  wire logic [oaht_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [oaht_pkg::CFG_W-1:0]       cfg_data,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [oaht_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [oaht_pkg::ST_W-1:0]             m_tuser
);

    localparam int SLOT_W = oaht_pkg::SLOT_W;
    localparam int CNT_W  = oaht_pkg::CNT_W;
    localparam int KEY_W  = oaht_pkg::KEY_W;

    // configuration
    logic [oaht_pkg::CFG_W-1:0] table_size_reg;
    logic [oaht_pkg::CFG_W-1:0] second_mod_reg;
    logic                       probe_mode_reg;
    logic [CNT_W-1:0]           size_used;
    logic [oaht_pkg::CFG_W-1:0] mod_used;

    // request and hash
    logic [KEY_W-1:0]           key_reg;
    oaht_pkg::dsel_t            dsel_reg;
    logic [SLOT_W-1:0]          hash_reg;
    logic [SLOT_W-1:0]          step_reg;
    logic [KEY_W-1:0]           div_dividend;
    logic [oaht_pkg::DVS_W-1:0] div_divisor;
    logic                       div_done;
    logic [oaht_pkg::DVS_W-1:0] div_rem;

    // probe pipeline
    logic [SLOT_W-1:0]          iss_pos_reg;
    logic [SLOT_W-1:0]          step_use_reg;
    logic [CNT_W-1:0]           iss_cnt_reg;
    logic                       chk_vld_reg;
    logic [SLOT_W-1:0]          chk_pos_reg;
    logic [CNT_W-1:0]           chk_cnt_reg;
    logic [CNT_W-1:0]           coll_reg;
    logic [oaht_pkg::TOTAL_W-1:0] total_reg;
    logic                       is_insert;
    logic                       issue;
    logic [CNT_W-1:0]           pos_sum;
    logic [CNT_W-1:0]           pos_wrap;
    logic                       occupied;
    logic                       key_eq;
    logic                       hit;
    logic                       last;
    logic                       collide;

    // slot memory: valid bit over key
    logic [KEY_W:0]             mem [oaht_pkg::SLOTS];
    logic [KEY_W:0]             mem_q_reg;
    logic                       mem_we;
    logic [SLOT_W-1:0]          mem_wa;
    logic [KEY_W:0]             mem_wd;
    logic                       mem_re;
    logic [SLOT_W-1:0]          wipe_addr_reg;

    // result and output stage
    logic [oaht_pkg::ST_W-1:0]  res_status_reg;
    logic [SLOT_W-1:0]          res_slot_reg;
    logic [oaht_pkg::ST_W-1:0]  res_status;
    logic                       out_valid_reg;
    logic [oaht_pkg::ST_W-1:0]  m_status_reg;
    logic [SLOT_W-1:0]          m_slot_reg;
    logic [CNT_W-1:0]           m_coll_reg;
    logic [oaht_pkg::TOTAL_W-1:0] m_total_reg;

    assign size_used = oaht_pkg::used_size(table_size_reg);
    assign mod_used  = oaht_pkg::used_mod(second_mod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= oaht_pkg::TABLE_SIZE_RST;
            second_mod_reg <= oaht_pkg::SECOND_MOD_RST;
            probe_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                oaht_pkg::CFG_TABLE_SIZE: table_size_reg <= cfg_data;
                oaht_pkg::CFG_SECOND_MOD: second_mod_reg <= cfg_data;
                oaht_pkg::CFG_PROBE_MODE: probe_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // remainder operands
    always_comb
    begin
        case (cmd.div_sel)
            oaht_pkg::DSEL_SECOND:
            begin
                div_dividend = key_reg;
                div_divisor  = oaht_pkg::DVS_W'(mod_used);
            end
            oaht_pkg::DSEL_STEP:
            begin
                div_dividend = KEY_W'(div_rem) + KEY_W'(1);
                div_divisor  = oaht_pkg::DVS_W'(size_used);
            end
            default:
            begin
                div_dividend = key_reg;
                div_divisor  = oaht_pkg::DVS_W'(size_used);
            end
        endcase
    end

    oaht_rem u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dsel_reg <= oaht_pkg::DSEL_HASH;
        else if (cmd.div_start)
            dsel_reg <= cmd.div_sel;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            key_reg <= key;
        if (div_done && dsel_reg == oaht_pkg::DSEL_HASH)
            hash_reg <= SLOT_W'(div_rem);
        if (div_done && dsel_reg == oaht_pkg::DSEL_STEP)
            step_reg <= SLOT_W'(div_rem);
    end

    // probe sequencing and slot check
    always_comb
    begin
        is_insert = (cmd.op == oaht_pkg::REQ_INSERT);
        issue     = (iss_cnt_reg < size_used);
        pos_sum   = {1'b0, iss_pos_reg} + {1'b0, step_use_reg};
        pos_wrap  = (pos_sum >= size_used) ? (pos_sum - size_used) : pos_sum;
        occupied  = mem_q_reg[KEY_W];
        key_eq    = (mem_q_reg[KEY_W-1:0] == key_reg);
        hit       = chk_vld_reg && (is_insert ? !occupied : (occupied && key_eq));
        last      = chk_vld_reg && ((chk_cnt_reg + CNT_W'(1)) == size_used);
        collide   = cmd.scan_en && chk_vld_reg && is_insert && occupied;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_cnt_reg <= '0;
            chk_vld_reg <= 1'b0;
            chk_cnt_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            iss_cnt_reg <= '0;
            chk_vld_reg <= 1'b0;
            chk_cnt_reg <= '0;
        end
        else if (cmd.scan_en)
        begin
            chk_vld_reg <= issue;
            if (issue)
                iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
            if (chk_vld_reg)
                chk_cnt_reg <= chk_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            iss_pos_reg  <= is_insert ? hash_reg : '0;
            step_use_reg <= (is_insert && probe_mode_reg) ? step_reg : SLOT_W'(1);
        end
        else if (cmd.scan_en && issue)
        begin
            iss_pos_reg <= SLOT_W'(pos_wrap);
            chk_pos_reg <= iss_pos_reg;
        end
    end

    // collision counters, total saturates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coll_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
                coll_reg <= '0;
            else if (collide)
                coll_reg <= coll_reg + CNT_W'(1);
            if (collide && total_reg != '1)
                total_reg <= total_reg + oaht_pkg::TOTAL_W'(1);
        end
    end

    // memory port: wipe pass or insert write, one probe read
    always_comb
    begin
        mem_we = cmd.wipe_en || (cmd.scan_en && is_insert && hit);
        mem_wa = cmd.wipe_en ? wipe_addr_reg : chk_pos_reg;
        mem_wd = cmd.wipe_en ? '0 : {1'b1, key_reg};
        mem_re = cmd.scan_en && issue;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_q_reg <= mem[iss_pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wipe_addr_reg <= '0;
        else if (cmd.wipe_en)
            wipe_addr_reg <= wipe_addr_reg + SLOT_W'(1);
    end

    // result capture
    always_comb
    begin
        case (cmd.op)
            oaht_pkg::REQ_INSERT: res_status = hit ? oaht_pkg::ST_INSERTED : oaht_pkg::ST_FULL;
            oaht_pkg::REQ_LOOKUP: res_status = hit ? oaht_pkg::ST_FOUND : oaht_pkg::ST_NOT_FOUND;
            default:              res_status = oaht_pkg::ST_CLEARED;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_status_reg <= res_status;
            res_slot_reg   <= (cmd.op != oaht_pkg::REQ_CLEAR && hit) ? chk_pos_reg : '0;
        end
        if (cmd.out_load)
        begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_coll_reg   <= coll_reg;
            m_total_reg  <= total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = oaht_pkg::OUT_DATA_W'({m_total_reg, m_coll_reg, m_slot_reg});

    always_comb
    begin
        stat.div_done    = div_done;
        stat.scan_done   = cmd.scan_en && (hit || last);
        stat.wipe_done   = cmd.wipe_en && (wipe_addr_reg == SLOT_W'(oaht_pkg::SLOTS - 1));
        stat.out_free    = !out_valid_reg || m_tready;
        stat.double_mode = probe_mode_reg;
    end

    `OAHT_ASSERT(a_issue_bound, cmd.scan_en |-> (iss_cnt_reg <= size_used), "probe issue overran table size")
    `OAHT_ASSERT(a_check_behind, cmd.scan_en |-> (chk_cnt_reg <= iss_cnt_reg), "slot checked before its read")
    `OAHT_ASSERT_NEXT(a_total_mono, 1'b1, total_reg >= $past(total_reg), "collision total went down")

endmodule

`default_nettype wire

### hdl/oaht_ctrl.sv
// ----------------------------------------------------------------------------
// oaht_ctrl
// request sequencer: hashing, probing, wipe pass and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
`include "open_addressing_hash_table_macros.svh"

module oaht_ctrl
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic [oaht_pkg::REQ_W-1:0]    req_type,
    output logic                               s_tready,
    input  wire oaht_pkg::oaht_stat_t          stat,
    output oaht_pkg::oaht_cmd_t                cmd
);

    localparam logic [3:0] S_BOOT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_DIVA     = 4'd3;
    localparam logic [3:0] S_DIVB     = 4'd4;
    localparam logic [3:0] S_DIVC     = 4'd5;
    localparam logic [3:0] S_PREP     = 4'd6;
    localparam logic [3:0] S_SCAN     = 4'd7;
    localparam logic [3:0] S_WIPE     = 4'd8;
    localparam logic [3:0] S_RESULT   = 4'd9;

    logic [3:0]                  state_reg, state_next;
    logic [oaht_pkg::REQ_W-1:0]  op_reg;

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = (state_reg == S_IDLE);
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.div_sel   = oaht_pkg::DSEL_HASH;
        case (state_reg)
            S_BOOT:
            begin
                cmd.wipe_en = 1'b1;
                if (stat.wipe_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (req_type inside {oaht_pkg::REQ_INSERT, oaht_pkg::REQ_LOOKUP,
                                         oaht_pkg::REQ_CLEAR})
                        state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    oaht_pkg::REQ_INSERT:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIVA;
                    end
                    oaht_pkg::REQ_LOOKUP: state_next = S_PREP;
                    oaht_pkg::REQ_CLEAR:  state_next = S_WIPE;
                    default:              state_next = S_IDLE;
                endcase
            end
            S_DIVA:
            begin
                if (stat.div_done)
                begin
                    if (stat.double_mode)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = oaht_pkg::DSEL_SECOND;
                        state_next    = S_DIVB;
                    end
                    else
                        state_next = S_PREP;
                end
            end
            S_DIVB:
            begin
                if (stat.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = oaht_pkg::DSEL_STEP;
                    state_next    = S_DIVC;
                end
            end
            S_DIVC:
            begin
                if (stat.div_done)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RESULT;
                end
            end
            S_WIPE:
            begin
                cmd.wipe_en = 1'b1;
                if (stat.wipe_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            op_reg    <= oaht_pkg::REQ_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.accept)
                op_reg <= req_type;
        end
    end

    `OAHT_ASSERT(a_boot_wiped, $fell(state_reg == S_BOOT) |-> $past(stat.wipe_done), "left boot before wipe pass ended")
    `OAHT_ASSERT_NEXT(a_capture_result, cmd.capture, state_reg == S_RESULT, "captured result not handed to output")

endmodule

`default_nettype wire
